### hdl/pps_pkg.sv
// Shared types and constants for the path point smoother.
// Holds the coordinate format, request structs, queue sizing and divide-by-three constants.
package pps_pkg;

    localparam int COORD_WIDTH = 32;

    // The sum of three coordinates needs two more bits, and its magnitude one more.
    localparam int SUM_W = COORD_WIDTH + 2;
    localparam int MAG_W = COORD_WIDTH + 1;

    // The magnitude is split into a high and a low part for the divide by three.
    localparam int LO_W = MAG_W / 2;
    localparam int HI_W = MAG_W - LO_W;
    localparam int A_W  = HI_W - 1;
    localparam int T_W  = LO_W + 2;
    localparam int B_W  = T_W - 1;

    // floor(v / 3) = (v * ceil(2^(k+1) / 3)) >> (k + 1) for any v below 2^k
    localparam logic [HI_W-1:0] DIV3_M_HI =
        HI_W'(((64'd1 << (HI_W + 1)) + 64'd2) / 64'd3);
    localparam logic [T_W-1:0] DIV3_M_LO =
        T_W'(((64'd1 << (T_W + 1)) + 64'd2) / 64'd3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t pt_x;
        coord_t pt_y;
        coord_t pt_heading;
        logic   is_last;
    } point_req_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_heading;
        logic   out_last;
    } result_req_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t heading;
    } point_t;

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO
    } seen_state_t;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_AVG,
        CMD_AVG_PASS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        point_t    older;
        point_t    newer;
        point_t    cur;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } queue_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } pipe_adv_t;

endpackage

### hdl/pps_front.sv
// Front end: accepts points, tracks the two-point window and classifies each point.
// Pushes pass or average requests into the queue; depends on pps_pkg.
module pps_front
    import pps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    output logic       point_stall,
    input  point_req_t point,
    input  logic       full,
    output queue_wr_t  wr
);

    seen_state_t state_reg, state_next;
    point_t      older_reg, older_next;
    point_t      newer_reg, newer_next;
    point_t      cur;
    logic        accept;

    assign point_stall = full;
    assign accept      = point_valid && !full;
    assign cur         = '{x: point.pt_x, y: point.pt_y, heading: point.pt_heading};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEEN_NONE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        older_reg <= older_next;
        newer_reg <= newer_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;
        wr.push       = 1'b0;
        wr.cmd.kind   = CMD_PASS;
        wr.cmd.older  = older_reg;
        wr.cmd.newer  = newer_reg;
        wr.cmd.cur    = cur;
        wr.cmd.last   = point.is_last;
        case (state_reg)
            SEEN_NONE:
            begin
                if (accept)
                begin
                    wr.push = 1'b1;
                    if (!point.is_last)
                    begin
                        newer_next = cur;
                        state_next = SEEN_ONE;
                    end
                end
            end
            SEEN_ONE:
            begin
                if (accept)
                begin
                    if (point.is_last)
                    begin
                        // two-point path: second point goes out unchanged
                        wr.push    = 1'b1;
                        state_next = SEEN_NONE;
                    end
                    else
                    begin
                        older_next = newer_reg;
                        newer_next = cur;
                        state_next = SEEN_TWO;
                    end
                end
            end
            SEEN_TWO:
            begin
                if (accept)
                begin
                    wr.push     = 1'b1;
                    wr.cmd.last = 1'b0;
                    if (point.is_last)
                    begin
                        wr.cmd.kind = CMD_AVG_PASS;
                        state_next  = SEEN_NONE;
                    end
                    else
                    begin
                        wr.cmd.kind = CMD_AVG;
                        older_next  = newer_reg;
                        newer_next  = cur;
                    end
                end
            end
            default:
            begin
                state_next = SEEN_NONE;
            end
        endcase
    end

endmodule

### hdl/pps_queue.sv
// Short request queue between the front end and the back end.
// Register-based FIFO of cmd_t entries; depends on pps_pkg.
module pps_queue
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_wr_t   wr,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

endmodule

### hdl/pps_mean_lane.sv
// One coordinate lane of the back end: sum of three, then truncating divide by three.
// Three pipeline stages split the reciprocal multiply in two halves; depends on pps_pkg.
module pps_mean_lane
    import pps_pkg::*;
(
    input  logic      clk,
    input  pipe_adv_t adv,
    input  coord_t    opa,
    input  coord_t    opb,
    input  coord_t    opc,
    output coord_t    mean
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_neg;
    logic [MAG_W-1:0]        mag_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg2_reg;

    logic [HI_W-1:0]         hi;
    logic [2*HI_W-1:0]       hprod;
    logic [A_W-1:0]          a3_reg;
    logic [HI_W-1:0]         hi3_reg;
    logic [LO_W-1:0]         lo3_reg;
    logic                    neg3_reg;

    logic [HI_W-1:0]         three_a;
    logic [HI_W-1:0]         rem_hi;
    logic [T_W-1:0]          t;
    logic [2*T_W-1:0]        lprod;
    logic [A_W-1:0]          a4_reg;
    logic [B_W-1:0]          b4_reg;
    logic                    neg4_reg;

    logic [COORD_WIDTH-1:0]  qmag;
    logic [COORD_WIDTH-1:0]  qneg;

    // stage 2: exact sum and its magnitude
    assign sum = {{2{opa[COORD_WIDTH-1]}}, opa}
               + {{2{opb[COORD_WIDTH-1]}}, opb}
               + {{2{opc[COORD_WIDTH-1]}}, opc};
    assign sum_neg  = -sum;
    assign mag_next = sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];

    // stage 3: quotient of the high part
    assign hi    = mag_reg[MAG_W-1:LO_W];
    assign hprod = (2*HI_W)'(hi) * (2*HI_W)'(DIV3_M_HI);

    // stage 4: fold the high remainder into the low part and divide that
    assign three_a = {a3_reg, 1'b0} + HI_W'(a3_reg);
    assign rem_hi  = hi3_reg - three_a;
    assign t       = {rem_hi[1:0], lo3_reg};
    assign lprod   = (2*T_W)'(t) * (2*T_W)'(DIV3_M_LO);

    assign qmag = {a4_reg, {LO_W{1'b0}}} + COORD_WIDTH'(b4_reg);
    assign qneg = -qmag;
    assign mean = coord_t'(neg4_reg ? qneg : qmag);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            mag_reg  <= mag_next;
            neg2_reg <= sum[SUM_W-1];
        end
        if (adv.s3)
        begin
            a3_reg   <= hprod[2*HI_W-1:HI_W+1];
            hi3_reg  <= hi;
            lo3_reg  <= mag_reg[LO_W-1:0];
            neg3_reg <= neg2_reg;
        end
        if (adv.s4)
        begin
            a4_reg   <= a3_reg;
            b4_reg   <= lprod[2*T_W-1:T_W+1];
            neg4_reg <= neg3_reg;
        end
    end

endmodule

### hdl/pps_back.sv
// Back end: pops requests, issues one pipeline entry per result, and drives the output.
// Uses three pps_mean_lane instances and an elastic valid pipeline; depends on pps_pkg.
module pps_back
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output result_req_t result
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        last1_reg, last2_reg, last3_reg, last4_reg;
    logic        rdy1, rdy2, rdy3, rdy4, rdy5;
    logic        sub_reg, sub_next;
    logic        issue_pass;
    logic        issue_last;
    point_t      opa_reg, opb_reg, opc_reg;
    point_t      opa_next, opb_next;
    pipe_adv_t   adv;
    coord_t      mean_x, mean_y, mean_h;
    result_req_t result_reg;

    // a ready slot ripples back from the output register
    assign rdy5 = !v5_reg || !result_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign adv.s2 = rdy2;
    assign adv.s3 = rdy3;
    assign adv.s4 = rdy4;

    always_comb
    begin
        issue_pass = 1'b0;
        issue_last = 1'b0;
        sub_next   = sub_reg;
        pop        = 1'b0;
        case (head.cmd.kind)
            CMD_PASS:
            begin
                issue_pass = 1'b1;
                issue_last = head.cmd.last;
                pop        = head.valid && rdy1;
            end
            CMD_AVG:
            begin
                pop = head.valid && rdy1;
            end
            CMD_AVG_PASS:
            begin
                // average first, then the last point itself
                issue_pass = sub_reg;
                issue_last = sub_reg;
                pop        = head.valid && rdy1 && sub_reg;
                if (head.valid && rdy1)
                begin
                    sub_next = !sub_reg;
                end
            end
            default:
            begin
                pop = head.valid && rdy1;
            end
        endcase
        // a pass result is cur*3/3, which is exact
        opa_next = issue_pass ? head.cmd.cur : head.cmd.older;
        opb_next = issue_pass ? head.cmd.cur : head.cmd.newer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (rdy1)
            begin
                v1_reg <= head.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
            opc_reg   <= head.cmd.cur;
            last1_reg <= issue_last;
        end
        if (rdy2)
        begin
            last2_reg <= last1_reg;
        end
        if (rdy3)
        begin
            last3_reg <= last2_reg;
        end
        if (rdy4)
        begin
            last4_reg <= last3_reg;
        end
        if (rdy5)
        begin
            result_reg.out_x       <= mean_x;
            result_reg.out_y       <= mean_y;
            result_reg.out_heading <= mean_h;
            result_reg.out_last    <= last4_reg;
        end
    end

    pps_mean_lane u_lane_x (
        .clk  (clk),
        .adv  (adv),
        .opa  (opa_reg.x),
        .opb  (opb_reg.x),
        .opc  (opc_reg.x),
        .mean (mean_x)
    );

    pps_mean_lane u_lane_y (
        .clk  (clk),
        .adv  (adv),
        .opa  (opa_reg.y),
        .opb  (opb_reg.y),
        .opc  (opc_reg.y),
        .mean (mean_y)
    );

    pps_mean_lane u_lane_h (
        .clk  (clk),
        .adv  (adv),
        .opa  (opa_reg.heading),
        .opb  (opb_reg.heading),
        .opc  (opc_reg.heading),
        .mean (mean_h)
    );

    assign result_valid = v5_reg;
    assign result       = result_reg;

endmodule

### hdl/path_point_smoother_top.sv
// Three-point moving average over a streamed path of (x, y, heading) points.
// Connects the front end, request queue and back end; depends on pps_pkg.
//
// Usage:
//   point channel (point_valid / point_stall / point) carries one path point per
//   request, is_last set on the final point. result channel (result_valid /
//   result_stall / result) returns smoothed points; out_last marks the path end.
//   The first and last points of a path pass unchanged, interior points become
//   the truncated mean of themselves and their two neighbors, paths of one or two
//   points pass unchanged. The second point of a path gives no result until the
//   third arrives; a final point of a longer path gives two results.
//   The extra pass-through result of a final point follows its averaged result.
//   Throughput: one point per cycle unless point_stall is high; the back end
//   issues one result per cycle unless stalled, so a path end costs the back end
//   an extra issue slot, absorbed by a 4-entry queue.
//   Reset clears the window state, queue and pipeline valids; no result is
//   pending afterward. When result_stall is high the output holds, the pipeline
//   fills, then the queue, and point_stall rises once the queue is full.
module path_point_smoother_top
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_stall,
    input  point_req_t  point,
    output logic        result_valid,
    input  logic        result_stall,
    output result_req_t result
);

    queue_wr_t   q_wr;
    queue_head_t q_head;
    logic        q_full;
    logic        q_pop;

    pps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .full        (q_full),
        .wr          (q_wr)
    );

    pps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    pps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full
    ) else $error("request pushed into a full queue");

    a_no_pop_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid
    ) else $error("request popped from an empty queue");

    a_full_has_head: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_full |-> q_head.valid
    ) else $error("queue full but no head request");

    a_stall_is_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |-> !q_full
    ) else $error("point accepted while queue full");

endmodule

### dv/path_point_smoother_checker.sv
// Checker for the path point smoother: watches both request channels and predicts results.
// Keeps its own three-point window and compares each result request in order; uses pps_pkg.
module path_point_smoother_checker
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    input  logic        point_stall,
    input  point_req_t  point,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_req_t result,
    output int          mismatches,
    output int          pending
);

    result_req_t expected_results[$];
    point_t      older_pt;
    point_t      newer_pt;
    seen_state_t seen;
    int          bad_count;

    // Sum exactly in SUM_W bits, then divide with truncation toward zero.
    function automatic coord_t mean3(coord_t a, coord_t b, coord_t c);
        logic signed [SUM_W-1:0] total;
        total = a + b + c;
        return coord_t'(total / 3);
    endfunction

    function automatic result_req_t to_result(point_t p, logic last);
        result_req_t r;
        r.out_x       = p.x;
        r.out_y       = p.y;
        r.out_heading = p.heading;
        r.out_last    = last;
        return r;
    endfunction

    task automatic add_expected(result_req_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic smooth_point(point_req_t p);
        point_t cur;
        point_t avg;
        cur.x       = p.pt_x;
        cur.y       = p.pt_y;
        cur.heading = p.pt_heading;
        case (seen)
            SEEN_NONE:
            begin
                add_expected(to_result(cur, p.is_last));
                if (!p.is_last)
                begin
                    newer_pt = cur;
                    seen     = SEEN_ONE;
                end
            end
            SEEN_ONE:
            begin
                if (p.is_last)
                begin
                    add_expected(to_result(cur, 1'b1));
                    seen = SEEN_NONE;
                end
                else
                begin
                    older_pt = newer_pt;
                    newer_pt = cur;
                    seen     = SEEN_TWO;
                end
            end
            default:
            begin
                avg.x       = mean3(older_pt.x, newer_pt.x, cur.x);
                avg.y       = mean3(older_pt.y, newer_pt.y, cur.y);
                avg.heading = mean3(older_pt.heading, newer_pt.heading, cur.heading);
                add_expected(to_result(avg, 1'b0));
                if (p.is_last)
                begin
                    add_expected(to_result(cur, 1'b1));
                    seen = SEEN_NONE;
                end
                else
                begin
                    older_pt = newer_pt;
                    newer_pt = cur;
                end
            end
        endcase
    endtask

    task automatic check_result(result_req_t got);
        result_req_t want;
        if (expected_results.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: unexpected result x=%0d y=%0d h=%0d last=%0b", $time,
                         got.out_x, got.out_y, got.out_heading, got.out_last);
            return;
        end
        want = expected_results.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_heading !== want.out_heading || got.out_last !== want.out_last)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: mismatch expected x=%0d y=%0d h=%0d last=%0b,",
                         $time, want.out_x, want.out_y, want.out_heading, want.out_last,
                         " got x=%0d y=%0d h=%0d last=%0b",
                         got.out_x, got.out_y, got.out_heading, got.out_last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            older_pt   = '0;
            newer_pt   = '0;
            seen       = SEEN_NONE;
            bad_count  = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (point_valid && !point_stall)
                smooth_point(point);
            mismatches <= bad_count;
            pending    <= expected_results.size();
        end
    end

endmodule

### dv/path_point_smoother_top_test.sv
// Testbench top for the path point smoother: clock, reset, point stimulus and result stalls.
// Instantiates the block and path_point_smoother_checker; uses pps_pkg.
module path_point_smoother_top_test;
    import pps_pkg::*;

    localparam int     TOTAL_POINTS = 900;
    localparam int     BURST_START  = 300;
    localparam int     BURST_END    = 420;
    localparam int     HOLD_CYCLES  = 200;
    localparam coord_t CMAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam coord_t CMIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_stall;
    point_req_t  point;
    logic        result_valid;
    logic        result_stall;
    result_req_t result;
    int          mismatches;
    int          pending;
    int          points_sent;

    path_point_smoother_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    path_point_smoother_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3200000;
        $display("Verification failed");
        $finish;
    end

    function automatic point_req_t mk_point(coord_t x, coord_t y, coord_t h, logic last);
        point_req_t p;
        p.pt_x       = x;
        p.pt_y       = y;
        p.pt_heading = h;
        p.is_last    = last;
        return p;
    endfunction

    function automatic coord_t pick_coord(int style);
        int r;
        r = $urandom_range(0, 9);
        case (style)
            0: return coord_t'({$urandom, $urandom});
            1:
            begin
                if (r < 3)
                    return CMAX;
                else if (r < 6)
                    return CMIN;
                else if (r < 7)
                    return '0;
                else if (r < 9)
                    return -1;
                else
                    return 1;
            end
            2: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
            default:
            begin
                if (r < 5)
                    return CMAX - coord_t'($urandom_range(0, 255));
                else
                    return CMIN + coord_t'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 10);
        else
            return $urandom_range(30, 60);
    endfunction

    // Hold the request until accepted; keep valid high when no gap follows.
    task automatic send_point(input point_req_t p, input int gap);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point       <= p;
        point_valid <= 1'b1;
        @(posedge clk);
        while (point_stall) @(posedge clk);
        points_sent++;
    endtask

    // Result side: random stalls, plus one long hold-off while points keep coming.
    initial
    begin : receiver
        int  r;
        int  n;
        bit  held_off;
        held_off     = 1'b0;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && points_sent >= BURST_START)
            begin
                held_off = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                begin
                    n = $urandom_range(1, 40);
                    result_stall <= 1'b0;
                end
                else if (r < 9)
                begin
                    n = $urandom_range(1, 3);
                    result_stall <= (r < 7);
                end
                else
                begin
                    n = $urandom_range(20, 60);
                    result_stall <= 1'b1;
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        point_req_t dir_pts[$];
        point_req_t p;
        int         len;
        int         style;
        bit         mixed;
        bit         quiet;
        int         gap;

        rst_n        = 1'b0;
        point_valid  = 1'b0;
        point        = '0;
        points_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-point path
        dir_pts.insert(dir_pts.size(), mk_point(CMAX, CMIN, '0, 1'b1));
        // two-point path
        dir_pts.insert(dir_pts.size(), mk_point(CMIN, CMAX, -1, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(1, -1, CMAX, 1'b1));
        // three points at the positive and negative ends, sums beyond the coordinate width
        repeat (2) dir_pts.insert(dir_pts.size(), mk_point(CMAX, CMAX, CMAX, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(CMAX, CMAX, CMAX, 1'b1));
        repeat (2) dir_pts.insert(dir_pts.size(), mk_point(CMIN, CMIN, CMIN, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(CMIN, CMIN, CMIN, 1'b1));
        // negative sums that truncate toward zero, not down
        dir_pts.insert(dir_pts.size(), mk_point(-1, -2, 1, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(0, -2, 1, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(0, -1, 0, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(-1, 5, -5, 1'b1));
        // alternating extremes
        dir_pts.insert(dir_pts.size(), mk_point(CMAX, CMIN, CMAX, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(CMIN, CMAX, CMIN, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point(CMAX, CMIN, -1, 1'b0));
        dir_pts.insert(dir_pts.size(), mk_point('0, '0, '0, 1'b1));
        // bit patterns
        dir_pts.insert(dir_pts.size(),
                       mk_point(coord_t'(32'h5555_5555), coord_t'(32'hAAAA_AAAA),
                                coord_t'(32'h0001_0000), 1'b0));
        dir_pts.insert(dir_pts.size(),
                       mk_point(coord_t'(32'hAAAA_AAAA), coord_t'(32'h5555_5555),
                                coord_t'(32'hFFFF_0000), 1'b0));
        dir_pts.insert(dir_pts.size(),
                       mk_point(coord_t'(32'h5555_5555), coord_t'(32'hAAAA_AAAA),
                                coord_t'(32'h0000_FFFF), 1'b1));

        foreach (dir_pts[i])
            send_point(dir_pts[i], pick_gap());

        while (points_sent < TOTAL_POINTS)
        begin
            len   = pick_len();
            style = $urandom_range(0, 3);
            mixed = ($urandom_range(0, 4) == 0);
            quiet = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                p.pt_x       = pick_coord(mixed ? $urandom_range(0, 3) : style);
                p.pt_y       = pick_coord(mixed ? $urandom_range(0, 3) : style);
                p.pt_heading = pick_coord(mixed ? $urandom_range(0, 3) : style);
                p.is_last    = (i == len - 1);
                // offer back to back across the hold-off so the block backs up
                if (quiet || (points_sent >= BURST_START && points_sent < BURST_END))
                    gap = 0;
                else
                    gap = pick_gap();
                send_point(p, gap);
            end
        end
        point_valid <= 1'b0;

        // let the pending count take in the last request before waiting on it
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
